### hw/rtl/wifi_mac_header_parser_core_assert.svh
// assertion macros for the header parser
`ifndef WIFI_MAC_HEADER_PARSER_CORE_ASSERT_SVH
`define WIFI_MAC_HEADER_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WMHP_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define WMHP_ASSERT(label, prop) `WMHP_ASSERT_IMPL(label, clk, rst_n, prop)
`else
`define WMHP_ASSERT_IMPL(label, clk, rst_n, prop)
`define WMHP_ASSERT(label, prop)
`endif
`endif

### hw/rtl/wmhp_pkg.sv
`default_nettype none
package wmhp_pkg;
    localparam logic [3:0] K_MGMT    = 4'd0;
    localparam logic [3:0] K_ACTION  = 4'd1;
    localparam logic [3:0] K_RTS     = 4'd2;
    localparam logic [3:0] K_CTS     = 4'd3;
    localparam logic [3:0] K_ACK     = 4'd4;
    localparam logic [3:0] K_BAR     = 4'd5;
    localparam logic [3:0] K_BA      = 4'd6;
    localparam logic [3:0] K_DATA    = 4'd7;
    localparam logic [3:0] K_QOS     = 4'd8;
    localparam logic [3:0] K_SHORT   = 4'd9;
    localparam logic [3:0] K_UNKNOWN = 4'd10;

    localparam logic [4:0] F_FC      = 5'd0;
    localparam logic [4:0] F_DUR     = 5'd1;
    localparam logic [4:0] F_ADDR1   = 5'd2;
    localparam logic [4:0] F_ADDR2   = 5'd3;
    localparam logic [4:0] F_ADDR3   = 5'd4;
    localparam logic [4:0] F_SEQ     = 5'd5;
    localparam logic [4:0] F_ADDR4   = 5'd6;
    localparam logic [4:0] F_QOS     = 5'd7;
    localparam logic [4:0] F_HT      = 5'd8;
    localparam logic [4:0] F_CAT     = 5'd9;
    localparam logic [4:0] F_BAACT   = 5'd10;
    localparam logic [4:0] F_DIALOG  = 5'd11;
    localparam logic [4:0] F_STATUS  = 5'd12;
    localparam logic [4:0] F_BAPARAM = 5'd13;
    localparam logic [4:0] F_BATMO   = 5'd14;
    localparam logic [4:0] F_SSC     = 5'd15;
    localparam logic [4:0] F_DELBA   = 5'd16;
    localparam logic [4:0] F_REASON  = 5'd17;
    localparam logic [4:0] F_BACTL   = 5'd18;
    localparam logic [4:0] F_BASSC   = 5'd19;
    localparam logic [4:0] F_BITMAP  = 5'd21;
    localparam logic [4:0] F_ERROR   = 5'd22;
    localparam logic [4:0] F_END     = 5'd31;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_TYPE    = 2'd1;
    localparam logic [1:0] E_ACTION  = 2'd2;
    localparam logic [1:0] E_MODE    = 2'd3;

    localparam logic [7:0] BA_CATEGORY  = 8'd3;
    localparam logic [7:0] BITMAP_BASIC = 8'd128;
    localparam logic [7:0] BITMAP_COMPR = 8'd8;

    typedef struct packed {
        logic        valid;
        logic [4:0]  code;
        logic [63:0] value;
        logic [3:0]  kind;
        logic [1:0]  err;
        logic        done;
    } wmhp_result_t;

    function automatic logic [3:0] field_len(input logic [4:0] f);
        case (f)
            F_ADDR1, F_ADDR2, F_ADDR3, F_ADDR4: field_len = 4'd6;
            F_HT:                               field_len = 4'd4;
            F_CAT, F_BAACT, F_DIALOG, F_BITMAP: field_len = 4'd1;
            default:                            field_len = 4'd2;
        endcase
    endfunction

    function automatic logic msb_first(input logic [4:0] f);
        msb_first = (f == F_ADDR1) || (f == F_ADDR2) || (f == F_ADDR3) || (f == F_ADDR4);
    endfunction

    function automatic logic [3:0] classify(input logic [15:0] fc);
        logic [1:0] ty;
        logic [3:0] sub;
        ty  = fc[3:2];
        sub = fc[7:4];
        classify = K_UNKNOWN;
        case (ty)
            2'd0:
            begin
                if (sub == 4'd13)
                    classify = K_ACTION;
                else if (sub <= 4'd5 || (sub >= 4'd8 && sub <= 4'd12) || sub == 4'd14)
                    classify = K_MGMT;
            end
            2'd1:
            begin
                case (sub)
                    4'd8:    classify = K_BAR;
                    4'd9:    classify = K_BA;
                    4'd10:   classify = K_SHORT;
                    4'd11:   classify = K_RTS;
                    4'd12:   classify = K_CTS;
                    4'd13:   classify = K_ACK;
                    default: classify = K_UNKNOWN;
                endcase
            end
            2'd2:
            begin
                if (sub == 4'd0)
                    classify = K_DATA;
                else if (sub == 4'd8)
                    classify = K_QOS;
            end
            default:
            begin
                if (sub <= 4'd1)
                    classify = K_SHORT;
            end
        endcase
    endfunction

    function automatic logic [4:0] next_after(input logic [3:0] kind, input logic [4:0] f,
                                              input logic [2:0] vf);
        logic       extra;
        logic [1:0] act;
        extra = vf[2];
        act   = vf[1:0];
        next_after = F_END;
        case (kind)
            K_MGMT:
            begin
                if (f < F_SEQ)
                    next_after = f + 5'd1;
                else if (f == F_SEQ && extra)
                    next_after = F_HT;
            end
            K_ACTION:
            begin
                if (f < F_SEQ)
                    next_after = f + 5'd1;
                else if (f == F_SEQ)
                    next_after = extra ? F_HT : F_CAT;
                else if (f == F_HT)
                    next_after = F_CAT;
                else if (f == F_CAT)
                    next_after = F_BAACT;
                else if (f == F_BAACT)
                    next_after = (act == 2'd2) ? F_DELBA : F_DIALOG;
                else if (f == F_DIALOG)
                    next_after = (act == 2'd1) ? F_STATUS : F_BAPARAM;
                else if (f == F_STATUS)
                    next_after = F_BAPARAM;
                else if (f == F_BAPARAM)
                    next_after = F_BATMO;
                else if (f == F_BATMO)
                    next_after = (act == 2'd0) ? F_SSC : F_END;
                else if (f == F_DELBA)
                    next_after = F_REASON;
            end
            K_RTS:
            begin
                if (f < F_ADDR2)
                    next_after = f + 5'd1;
            end
            K_CTS, K_ACK:
            begin
                if (f < F_ADDR1)
                    next_after = f + 5'd1;
            end
            K_BAR, K_BA:
            begin
                if (f < F_ADDR2)
                    next_after = f + 5'd1;
                else if (f == F_ADDR2)
                    next_after = F_BACTL;
                else if (f == F_BACTL)
                    next_after = F_BASSC;
                else if (f == F_BASSC && kind == K_BA)
                    next_after = F_BITMAP;
            end
            K_DATA:
            begin
                if (f < F_SEQ)
                    next_after = f + 5'd1;
                else if (f == F_SEQ && extra)
                    next_after = F_ADDR4;
            end
            K_QOS:
            begin
                if (f < F_SEQ)
                    next_after = f + 5'd1;
                else if (f == F_SEQ)
                    next_after = extra ? F_ADDR4 : F_QOS;
                else if (f == F_ADDR4)
                    next_after = F_QOS;
            end
            default: next_after = F_END;
        endcase
    endfunction
endpackage
`default_nettype wire

### hw/rtl/wmhp_parse.sv
`default_nettype none
module wmhp_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_take,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  frame_start,
    output wmhp_pkg::wmhp_result_t     res,
    output logic                       idle
);
    import wmhp_pkg::*;

    logic        fin_reg, fin_next;
    logic [3:0]  kind_reg, kind_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  left_reg, left_next;
    logic [4:0]  cur_reg, cur_next;
    logic [2:0]  vf_reg, vf_next;
    logic [7:0]  bm_reg, bm_next;

    always_comb
    begin
        logic [4:0]  f;
        logic [3:0]  len, left, kind;
        logic [2:0]  vf, idx;
        logic [63:0] acc, v;
        logic [7:0]  bm;
        logic [4:0]  n;
        logic [15:0] fc;
        logic        stop;
        fin_next  = fin_reg;
        kind_next = kind_reg;
        acc_next  = acc_reg;
        left_next = left_reg;
        cur_next  = cur_reg;
        vf_next   = vf_reg;
        bm_next   = bm_reg;
        res       = '0;
        f    = cur_reg;
        left = left_reg;
        kind = kind_reg;
        vf   = vf_reg;
        acc  = acc_reg;
        bm   = bm_reg;
        len  = '0;
        idx  = '0;
        v    = '0;
        n    = F_END;
        fc   = '0;
        stop = 1'b0;
        if (in_take && (frame_start || !fin_reg))
        begin
            if (frame_start)
            begin
                kind = K_MGMT;
                vf   = '0;
                bm   = '0;
                f    = F_FC;
                left = 4'd2;
                acc  = '0;
            end
            fin_next = 1'b0;
            if (f == F_BITMAP)
            begin
                if (bm != 8'd0)
                    bm = bm - 8'd1;
                res.valid = 1'b1;
                res.code  = F_BITMAP;
                res.value = {56'd0, rx_byte};
                res.kind  = kind;
                res.done  = (bm == 8'd0);
                fin_next  = (bm == 8'd0);
            end
            else
            begin
                len = field_len(f);
                if (left == 4'd0 || left > len)
                    left = len;
                idx = 3'(len - left);
                if (msb_first(f))
                    acc = {acc[55:0], rx_byte};
                else
                    acc = acc | ({56'd0, rx_byte} << {idx, 3'b000});
                left = left - 4'd1;
                if (left == 4'd0)
                begin
                    v = acc;
                    res.valid = 1'b1;
                    res.code  = f;
                    if (f == F_FC)
                    begin
                        fc   = acc[15:0];
                        kind = classify(fc);
                        if (kind == K_UNKNOWN)
                        begin
                            res.code = F_ERROR;
                            res.err  = E_TYPE;
                            stop = 1'b1;
                        end
                        else if (kind == K_SHORT)
                            stop = 1'b1;
                        else if (kind == K_MGMT || kind == K_ACTION)
                            vf = {fc[15], 2'b00};
                        else if (kind == K_DATA || kind == K_QOS)
                            vf = {fc[9] & fc[8], 2'b00};
                        else
                            vf = '0;
                    end
                    else if (f == F_CAT && kind == K_ACTION)
                    begin
                        if (acc != {56'd0, BA_CATEGORY})
                        begin
                            res.code = F_ERROR;
                            res.err  = E_ACTION;
                            stop = 1'b1;
                        end
                    end
                    else if (f == F_BAACT && kind == K_ACTION)
                    begin
                        if (acc > 64'd2)
                        begin
                            res.code = F_ERROR;
                            res.err  = E_ACTION;
                            stop = 1'b1;
                        end
                        else
                            vf = {vf[2], acc[1:0]};
                    end
                    else if (f == F_BACTL)
                    begin
                        if (acc[1])
                        begin
                            res.code = F_ERROR;
                            res.err  = E_MODE;
                            stop = 1'b1;
                        end
                        else
                            vf = {2'b00, acc[2]};
                    end
                    else if (f == F_BATMO)
                        v = {acc[53:0], 10'd0};
                    if (!stop)
                        n = next_after(kind, f, vf);
                    res.value = v;
                    res.kind  = kind;
                    if (stop || n == F_END)
                    begin
                        res.done = 1'b1;
                        fin_next = 1'b1;
                    end
                    else if (n == F_BITMAP)
                    begin
                        f    = F_BITMAP;
                        left = '0;
                        acc  = '0;
                        bm   = vf[0] ? BITMAP_COMPR : BITMAP_BASIC;
                    end
                    else
                    begin
                        f    = n;
                        left = field_len(n);
                        acc  = '0;
                    end
                end
            end
            kind_next = kind;
            vf_next   = vf;
            bm_next   = bm;
            cur_next  = f;
            left_next = left;
            acc_next  = acc;
        end
    end

    assign idle = fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg  <= 1'b1;
            kind_reg <= '0;
            left_reg <= '0;
            cur_reg  <= '0;
            vf_reg   <= '0;
            bm_reg   <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            fin_reg  <= fin_next;
            kind_reg <= kind_next;
            left_reg <= left_next;
            cur_reg  <= cur_next;
            vf_reg   <= vf_next;
            bm_reg   <= bm_next;
            acc_reg  <= acc_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/wmhp_out.sv
`default_nettype none
module wmhp_out (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wmhp_pkg::wmhp_result_t res,
    input  wire logic                   out_stall,
    output logic                        in_stall,
    output logic                        out_valid,
    output logic [4:0]                  field_code,
    output logic [63:0]                 field_value,
    output logic [3:0]                  frame_kind,
    output logic [1:0]                  error_code,
    output logic                        header_done
);
    import wmhp_pkg::*;

    wmhp_result_t main_reg, main_next, skid_reg, skid_next;

    // skid holds one result when the output is stalled
    assign in_stall = skid_reg.valid;

    always_comb
    begin
        main_next = main_reg;
        skid_next = skid_reg;
        if (!main_reg.valid || !out_stall)
        begin
            if (skid_reg.valid)
            begin
                main_next = skid_reg;
                skid_next.valid = 1'b0;
                if (res.valid)
                    skid_next = res;
            end
            else
                main_next = res;
        end
        else if (res.valid)
            skid_next = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg <= '0;
            skid_reg <= '0;
        end
        else
        begin
            main_reg <= main_next;
            skid_reg <= skid_next;
        end
    end

    assign out_valid   = main_reg.valid;
    assign field_code  = main_reg.code;
    assign field_value = main_reg.value;
    assign frame_kind  = main_reg.kind;
    assign error_code  = main_reg.err;
    assign header_done = main_reg.done;
endmodule
`default_nettype wire

### hw/rtl/wifi_mac_header_parser_core.sv
`default_nettype none
// 802.11 mac header parser: one header byte per item, one result at most per item,
// a new byte accepted every cycle while in_stall is low. a result is decoded
// combinationally from the byte that ends its field and registered in a two-entry
// output buffer, which keeps input flowing while the output is stalled until a
// second result waits; in_stall then holds until the output takes the first one.
module wifi_mac_header_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       field_code,
    output logic [63:0]      field_value,
    output logic [3:0]       frame_kind,
    output logic [1:0]       error_code,
    output logic             header_done
);
    import wmhp_pkg::*;

    wmhp_result_t res;
    logic         idle;
    logic         in_take;

    assign in_take = in_valid && !in_stall;

    wmhp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .res         (res),
        .idle        (idle)
    );

    wmhp_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .out_stall   (out_stall),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .field_code  (field_code),
        .field_value (field_value),
        .frame_kind  (frame_kind),
        .error_code  (error_code),
        .header_done (header_done)
    );

`include "wifi_mac_header_parser_core_assert.svh"
    `WMHP_ASSERT(a_idle_no_result, (idle && in_take && !frame_start) |-> !res.valid)
    `WMHP_ASSERT(a_done_goes_idle, (res.valid && res.done) |=> idle)
    `WMHP_ASSERT(a_err_code, (out_valid && field_code == F_ERROR) |-> (error_code != E_NONE))
endmodule
`default_nettype wire
